FILE: hdl/svb_pkg.sv
package svb_pkg;

  localparam int unsigned TRACKED_ENTRIES = 65536;
  localparam int unsigned WORD_BITS       = 32;

  localparam int unsigned STORE_WORDS = (TRACKED_ENTRIES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned BIT_W       = $clog2(WORD_BITS);
  localparam int unsigned WADDR_W     = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;

  localparam int unsigned IDX_W  = 16;
  localparam int unsigned FUNC_W = 2;

  localparam logic [FUNC_W-1:0] FUNC_MARK_VALID   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_MARK_INVALID = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CHECK        = 2'd2;

  // Per-word operation: function code and the inclusive bit span inside the word.
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [BIT_W-1:0]  lo_bit;
    logic [BIT_W-1:0]  hi_bit;
  } word_ctrl_t;

endpackage

FILE: hdl/svb_word_op.sv
module svb_word_op (
  input  logic [svb_pkg::WORD_BITS-1:0] word_i,
  input  svb_pkg::word_ctrl_t           ctrl_i,
  output logic [svb_pkg::WORD_BITS-1:0] word_o,
  output logic                          all_set_o
);
  import svb_pkg::*;

  logic [WORD_BITS-1:0] ones;
  logic [WORD_BITS-1:0] mask;
  logic [BIT_W-1:0]     top_gap;

  assign ones    = '1;
  assign top_gap = BIT_W'(WORD_BITS - 1) - ctrl_i.hi_bit;
  assign mask    = (ones << ctrl_i.lo_bit) & (ones >> top_gap);

  always_comb begin
    case (ctrl_i.func)
      FUNC_MARK_VALID:   word_o = word_i | mask;
      FUNC_MARK_INVALID: word_o = word_i & ~mask;
      default:           word_o = word_i;
    endcase
  end

  assign all_set_o = ((word_i & mask) == mask);

endmodule

FILE: hdl/shadow_valid_bitmap_core.sv
// Valid bitmap over TRACKED_ENTRIES locations, packed WORD_BITS to a word in a
// synchronous RAM. A request names an operation in tuser and an inclusive index
// range in tdata, and yields one result beat. Requests are handled one at a
// time. Each word of the range passes through a read state (ST_RD) and a
// modify-write state (ST_MOD); then ST_FIN loads the result register and the
// block returns to idle. Empty ranges, out-of-range indices and the unused code
// go from idle straight to ST_FIN. A result that is still waiting holds the
// next one back in ST_FIN. After reset the RAM is swept to all-invalid, all
// STORE_WORDS words (2048 here), while tready stays low. A result waiting in
// the output register does not stop the next request from being accepted.
module shadow_valid_bitmap_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] start_index, [31:16] end_index
  input  logic [1:0]  s_axis_tuser,   // [1:0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // [0] all_valid, [1] range_error, [7:2] zero
);
  import svb_pkg::*;

  typedef enum logic [4:0] {
    ST_CLR  = 5'b00001,
    ST_IDLE = 5'b00010,
    ST_RD   = 5'b00100,
    ST_MOD  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [WADDR_W-1:0] clr_cnt_q, clr_cnt_d;
  logic [WADDR_W-1:0] cur_word_q, cur_word_d;
  logic [WADDR_W-1:0] first_word_q, first_word_d;
  logic [WADDR_W-1:0] last_word_q, last_word_d;
  logic [BIT_W-1:0]   first_bit_q, first_bit_d;
  logic [BIT_W-1:0]   last_bit_q, last_bit_d;
  logic [FUNC_W-1:0]  func_q, func_d;
  logic               acc_q, acc_d;
  logic               err_q, err_d;
  logic               out_valid_q, out_valid_d;
  logic               out_av_q, out_av_d;
  logic               out_err_q, out_err_d;

  logic [WORD_BITS-1:0] bitmap_q [STORE_WORDS];
  logic [WORD_BITS-1:0] rdata_q;
  logic                 mem_re;
  logic                 mem_we;
  logic [WADDR_W-1:0]   mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;

  logic [IDX_W-1:0] in_start;
  logic [IDX_W-1:0] in_end;
  logic [31:0]      start_word_full;
  logic [31:0]      end_word_full;
  logic             in_err;
  logic             in_skip;
  logic             in_accept;
  logic             out_free;

  word_ctrl_t           op_ctrl;
  logic [WORD_BITS-1:0] op_word;
  logic                 op_all_set;

  assign in_start        = s_axis_tdata[15:0];
  assign in_end          = s_axis_tdata[31:16];
  assign start_word_full = 32'(in_start) >> BIT_W;
  assign end_word_full   = 32'(in_end) >> BIT_W;
  assign in_err          = (32'(in_start) >= TRACKED_ENTRIES) ||
                           (32'(in_end) >= TRACKED_ENTRIES);
  assign in_skip         = in_err || (in_start > in_end) ||
                           !((s_axis_tuser == FUNC_MARK_VALID) ||
                             (s_axis_tuser == FUNC_MARK_INVALID) ||
                             (s_axis_tuser == FUNC_CHECK));

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign op_ctrl.func   = func_q;
  assign op_ctrl.lo_bit = (cur_word_q == first_word_q) ? first_bit_q : '0;
  assign op_ctrl.hi_bit = (cur_word_q == last_word_q) ? last_bit_q : '1;

  svb_word_op u_word_op (
    .word_i    (rdata_q),
    .ctrl_i    (op_ctrl),
    .word_o    (op_word),
    .all_set_o (op_all_set)
  );

  always_comb begin
    state_d      = state_q;
    clr_cnt_d    = clr_cnt_q;
    cur_word_d   = cur_word_q;
    first_word_d = first_word_q;
    last_word_d  = last_word_q;
    first_bit_d  = first_bit_q;
    last_bit_d   = last_bit_q;
    func_d       = func_q;
    acc_d        = acc_q;
    err_d        = err_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_av_d     = out_av_q;
    out_err_d    = out_err_q;
    mem_re       = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = cur_word_q;
    mem_wdata    = op_word;

    unique case (state_q)
      ST_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = '0;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == WADDR_W'(STORE_WORDS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          func_d       = s_axis_tuser;
          err_d        = in_err;
          acc_d        = 1'b1;
          first_word_d = start_word_full[WADDR_W-1:0];
          last_word_d  = end_word_full[WADDR_W-1:0];
          cur_word_d   = start_word_full[WADDR_W-1:0];
          first_bit_d  = in_start[BIT_W-1:0];
          last_bit_d   = in_end[BIT_W-1:0];
          state_d      = in_skip ? ST_FIN : ST_RD;
        end
      end
      ST_RD: begin
        mem_re  = 1'b1;
        state_d = ST_MOD;
      end
      ST_MOD: begin
        // The word read in ST_RD is written back here; the next read is of
        // the following word, so no access to one entry overlaps another.
        mem_we = (func_q == FUNC_MARK_VALID) || (func_q == FUNC_MARK_INVALID);
        acc_d  = acc_q && op_all_set;
        if (cur_word_q == last_word_q) begin
          state_d = ST_FIN;
        end else begin
          cur_word_d = cur_word_q + 1'b1;
          state_d    = ST_RD;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_av_d    = !err_q && (func_q == FUNC_CHECK) && acc_q;
          out_err_d   = err_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_word_q   <= cur_word_d;
    first_word_q <= first_word_d;
    last_word_q  <= last_word_d;
    first_bit_q  <= first_bit_d;
    last_bit_q   <= last_bit_d;
    func_q       <= func_d;
    acc_q        <= acc_d;
    err_q        <= err_d;
    out_av_q     <= out_av_d;
    out_err_q    <= out_err_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      bitmap_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= bitmap_q[cur_word_q];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_err_q, out_av_q};

`ifndef SYNTHESIS
  a_write_only_when_owned : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> ((state_q == ST_CLR) || (state_q == ST_MOD)))
    else $error("bitmap written outside clearing or modify");

  a_no_accept_while_clearing : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLR) |-> !s_axis_tready)
    else $error("request accepted during clearing pass");

  a_walk_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MOD) |-> ((cur_word_q >= first_word_q) && (cur_word_q <= last_word_q)))
    else $error("word walk left the requested range");

  a_error_not_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[1]) |-> !m_axis_tdata[0])
    else $error("range error reported together with all_valid");
`endif

endmodule

FILE: dv/tb.sv
module tb;
  import svb_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 1650;
  localparam int unsigned PRINT_CAP = 60;

  typedef struct packed {
    logic all_valid;
    logic range_error;
  } verdict_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [IDX_W-1:0]  lo;
    logic [IDX_W-1:0]  hi;
    logic              typed;
    logic              av;
    logic              err;
  } stim_row_t;

  localparam int unsigned N_DIRECTED = 25;

  // Rows with typed set carry a result that follows directly from the state
  // built up by the rows above; the others are left to the bitmap model.
  localparam stim_row_t DIRECTED [0:N_DIRECTED-1] = '{
    '{FUNC_CHECK,        16'h0000, 16'h0000, 1'b1, 1'b0, 1'b0},
    '{FUNC_CHECK,        16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b0},
    '{FUNC_CHECK,        16'h0005, 16'h0003, 1'b1, 1'b1, 1'b0},
    '{FUNC_UNUSED,       16'h0000, 16'hFFFF, 1'b1, 1'b0, 1'b0},
    '{FUNC_MARK_VALID,   16'h0000, 16'hFFFF, 1'b1, 1'b0, 1'b0},
    '{FUNC_CHECK,        16'h0000, 16'hFFFF, 1'b1, 1'b1, 1'b0},
    '{FUNC_MARK_INVALID, 16'h0064, 16'h0064, 1'b1, 1'b0, 1'b0},
    '{FUNC_CHECK,        16'h0000, 16'hFFFF, 1'b0, 1'b0, 1'b0},
    '{FUNC_CHECK,        16'h0065, 16'hFFFF, 1'b0, 1'b0, 1'b0},
    '{FUNC_CHECK,        16'h0063, 16'h0063, 1'b0, 1'b0, 1'b0},
    '{FUNC_MARK_INVALID, 16'h0000, 16'hFFFF, 1'b1, 1'b0, 1'b0},
    '{FUNC_CHECK,        16'hFFFF, 16'h0000, 1'b1, 1'b1, 1'b0},
    '{FUNC_MARK_VALID,   16'h001F, 16'h0020, 1'b1, 1'b0, 1'b0},
    '{FUNC_CHECK,        16'h001F, 16'h0020, 1'b0, 1'b0, 1'b0},
    '{FUNC_CHECK,        16'h001E, 16'h0020, 1'b0, 1'b0, 1'b0},
    '{FUNC_MARK_VALID,   16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b0},
    '{FUNC_CHECK,        16'hFFE0, 16'hFFFF, 1'b0, 1'b0, 1'b0},
    '{FUNC_MARK_VALID,   16'h0000, 16'h001F, 1'b1, 1'b0, 1'b0},
    '{FUNC_CHECK,        16'h0000, 16'h001F, 1'b0, 1'b0, 1'b0},
    '{FUNC_MARK_INVALID, 16'h0020, 16'h003F, 1'b1, 1'b0, 1'b0},
    '{FUNC_CHECK,        16'h001F, 16'h001F, 1'b0, 1'b0, 1'b0},
    '{FUNC_UNUSED,       16'hFFFF, 16'h0000, 1'b1, 1'b0, 1'b0},
    '{FUNC_MARK_VALID,   16'h5555, 16'hAAAA, 1'b1, 1'b0, 1'b0},
    '{FUNC_CHECK,        16'h5555, 16'hAAAA, 1'b0, 1'b0, 1'b0},
    '{FUNC_MARK_INVALID, 16'h5555, 16'hAAAA, 1'b1, 1'b0, 1'b0}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [15:0] start_index, [31:16] end_index
  logic [1:0]  s_axis_tuser;   // [1:0] func
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // [0] all_valid, [1] range_error, [7:2] zero

  bit       valid_map [TRACKED_ENTRIES];
  verdict_t pending_verdicts [$];
  int       mismatch_count;
  int       results_seen;
  int       items_sent;
  bit       quiet_phase;
  bit       pressure_done;

  shadow_valid_bitmap_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #4 clk_i = ~clk_i;

  // Bitmap model: applies one request and returns the verdict it produces.
  function automatic verdict_t apply_request(logic [FUNC_W-1:0] func,
                                             int unsigned lo, int unsigned hi);
    verdict_t v;
    v = '0;
    if (lo >= TRACKED_ENTRIES || hi >= TRACKED_ENTRIES) begin
      v.range_error = 1'b1;
    end else if (func == FUNC_MARK_VALID) begin
      for (int unsigned i = lo; i <= hi; i++) valid_map[i] = 1'b1;
    end else if (func == FUNC_MARK_INVALID) begin
      for (int unsigned i = lo; i <= hi; i++) valid_map[i] = 1'b0;
    end else if (func == FUNC_CHECK) begin
      v.all_valid = 1'b1;
      for (int unsigned i = lo; i <= hi; i++) begin
        if (!valid_map[i]) begin
          v.all_valid = 1'b0;
          break;
        end
      end
    end
    return v;
  endfunction

  function automatic int idle_cycles();
    int r;
    if (quiet_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(string what, int expected_val, int got_val);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("mismatch at %0t: %s expected %0d got %0d (result %0d)",
               $realtime, what, expected_val, got_val, results_seen);
  endtask

  // Entered and left in a rising-edge step; tvalid stays high on return so
  // back-to-back beats never drop it.
  task automatic send_request(logic [FUNC_W-1:0] func, int unsigned lo, int unsigned hi,
                              bit typed = 1'b0, bit av = 1'b0, bit err = 1'b0);
    int       gap;
    verdict_t v;
    gap = idle_cycles();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {hi[15:0], lo[15:0]};
    do @(posedge clk_i); while (!s_axis_tready);
    v = apply_request(func, lo, hi);
    if (typed) begin
      v.all_valid   = av;
      v.range_error = err;
    end
    pending_verdicts.push_back(v);
    items_sent++;
  endtask

  function automatic logic [FUNC_W-1:0] pick_func();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return FUNC_MARK_VALID;
    if (r < 50) return FUNC_MARK_INVALID;
    if (r < 95) return FUNC_CHECK;
    return FUNC_UNUSED;
  endfunction

  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("result beat with nothing pending, tdata", 0, m_axis_tdata);
      end else begin
        want = pending_verdicts.pop_front();
        if (m_axis_tdata[0] !== want.all_valid)
          report_mismatch("all_valid", want.all_valid, m_axis_tdata[0]);
        if (m_axis_tdata[1] !== want.range_error)
          report_mismatch("range_error", want.range_error, m_axis_tdata[1]);
        if (m_axis_tdata[7:2] !== 6'd0)
          report_mismatch("tdata padding", 0, m_axis_tdata[7:2]);
      end
      results_seen++;
    end
  end

  // Result side: random backpressure, plus one long hold-off that lets the
  // block fill up and stall its request side.
  initial begin
    int gap;
    m_axis_tready = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!pressure_done && results_seen >= 300) begin
        m_axis_tready <= 1'b0;
        repeat (500) @(posedge clk_i);
        pressure_done = 1'b1;
      end
      gap = idle_cycles();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  initial begin
    int unsigned base, a, b, c, d, x, lo, hi;
    int          r;
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = FUNC_MARK_VALID;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int k = 0; k < N_DIRECTED; k++)
      send_request(DIRECTED[k].func, DIRECTED[k].lo, DIRECTED[k].hi,
                   DIRECTED[k].typed, DIRECTED[k].av, DIRECTED[k].err);

    // Most traffic stays inside a small window so checks land on marked bits.
    base = 0;
    while (items_sent < N_DIRECTED + RANDOM_ITEMS) begin
      if (items_sent % 200 < 4) base = $urandom_range(0, 65535 - 255);
      quiet_phase = (items_sent / 150) % 4 == 3;
      r = $urandom_range(0, 99);
      if (r < 35) begin
        a = base + $urandom_range(0, 150);
        b = a + $urandom_range(0, 100);
        c = $urandom_range(a, b);
        d = $urandom_range(c, b);
        send_request(FUNC_MARK_VALID, a, b);
        send_request(FUNC_CHECK, c, d);
        if ($urandom_range(0, 1)) begin
          x = $urandom_range(c, d);
          send_request(FUNC_MARK_INVALID, x, x);
          send_request(FUNC_CHECK, c, d);
        end
      end else if (r < 80) begin
        lo = base + $urandom_range(0, 200);
        hi = lo + $urandom_range(0, 55);
        send_request(pick_func(), lo, hi);
      end else if (r < 90) begin
        hi = $urandom_range(0, 65534);
        lo = $urandom_range(hi + 1, 65535);
        send_request(pick_func(), lo, hi);
      end else if (r < 98) begin
        lo = $urandom_range(0, 65535);
        x  = $urandom_range(0, 40);
        hi = (lo + x > 65535) ? 65535 : lo + x;
        send_request(pick_func(), lo, hi);
      end else begin
        lo = $urandom_range(0, 65535);
        hi = $urandom_range(lo, 65535);
        send_request(pick_func(), lo, hi);
      end
    end
    quiet_phase = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
    if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
